// ===== rtl/core/bba_pkg.sv =====
// ---------------------------------------------------------------------------
// bba_pkg: shared types and constants of the buddy block allocator
// Node codes, request and status codes, field widths and the sequencer states.
// ---------------------------------------------------------------------------
package bba_pkg;

   localparam int TREE_LEVELS_DEF = 10;
   localparam int SHIFT_W         = 5;
   localparam int MAX_SHIFT       = 16;
   localparam int SIZE_W          = 27;
   localparam int OFS_W           = 26;
   localparam int UNITS_W         = 28;

   localparam logic [1:0] NODE_FREE  = 2'd0;
   localparam logic [1:0] NODE_SPLIT = 2'd1;
   localparam logic [1:0] NODE_ALLOC = 2'd2;

   localparam logic [1:0] REQ_ALLOC    = 2'd0;
   localparam logic [1:0] REQ_FREE     = 2'd1;
   localparam logic [1:0] REQ_FREE_ALL = 2'd2;
   localparam logic [1:0] REQ_RSVD     = 2'd3;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_NO_FIT = 2'd1;
   localparam logic [1:0] STATUS_BAD_FR = 2'd2;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_A_LVL,
      ST_A_RD,
      ST_A_CHK,
      ST_A_UP,
      ST_A_SPLIT,
      ST_F_RD,
      ST_F_CHK,
      ST_M_RD,
      ST_M_CHK,
      ST_RESP
   } bba_state_type;

endpackage

// ===== rtl/core/bba_node_ram.sv =====
// ---------------------------------------------------------------------------
// bba_node_ram: node state store
// One address per cycle, write or read, read data registered.
// ---------------------------------------------------------------------------
module bba_node_ram
   import bba_pkg::*;
#(
   parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic                 re,
   input  logic [TREE_LEVELS:0] addr,
   input  logic [1:0]           wdata,
   output logic [1:0]           rdata
);

   localparam int NODES = (2 ** (TREE_LEVELS + 1)) - 1;

   logic [1:0] mem [NODES];
   logic [1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/bba_ctrl.sv =====
// ---------------------------------------------------------------------------
// bba_ctrl: request sequencer
// Walks the node store one node at a time for clear, search, split, free and merge.
// ---------------------------------------------------------------------------
module bba_ctrl
   import bba_pkg::*;
#(
   parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           req_type,
   input  logic [SIZE_W-1:0]    req_request_size,
   input  logic [OFS_W-1:0]     req_free_offset,
   input  logic [SHIFT_W-1:0]   shift,
   output logic                 busy,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [OFS_W-1:0]     rsp_block_offset,
   output logic [SIZE_W-1:0]    rsp_grant_size,
   output logic                 ram_we,
   output logic                 ram_re,
   output logic [TREE_LEVELS:0] ram_addr,
   output logic [1:0]           ram_wdata,
   input  logic [1:0]           ram_rdata
);

   localparam int AW     = TREE_LEVELS + 1;
   localparam int DW     = $clog2(TREE_LEVELS + 1);
   localparam int NODES  = (2 ** AW) - 1;
   localparam int LEAF_N = 2 ** TREE_LEVELS;

   bba_state_type state_ff, state_in;
   logic [AW-1:0]      node_ff, node_in, best_ff, best_in;
   logic [DW-1:0]      depth_ff, depth_in, bestd_ff, bestd_in, dmax_ff, dmax_in;
   logic               hit_ff, hit_in, clr_rsp_ff, clr_rsp_in;
   logic [UNITS_W-1:0] units_ff, units_in;
   logic [1:0]         status_ff, status_in;
   logic [OFS_W-1:0]   ofs_ff, ofs_in;
   logic [SIZE_W-1:0]  size_ff, size_in;

   logic [UNITS_W-1:0] add_sum, units_raw;
   logic [OFS_W-1:0]   leaf;
   logic [AW-1:0]      sibling, parent, blk_idx;
   logic [5:0]         shamt;
   logic [63:0]        size_wide, ofs_wide;
   logic               take;

   always_comb begin
      add_sum   = {1'b0, req_request_size} + (UNITS_W'(1) << shift) - UNITS_W'(1);
      units_raw = add_sum >> shift;
      leaf      = req_free_offset >> shift;
      sibling   = node_ff[0] ? node_ff + AW'(1) : node_ff - AW'(1);
      parent    = (node_ff - AW'(1)) >> 1;
      blk_idx   = node_ff + AW'(1) - (AW'(1) << dmax_ff);
      shamt     = 6'(shift) + 6'(TREE_LEVELS) - 6'(dmax_ff);
      size_wide = 64'd1 << shamt;
      ofs_wide  = 64'(blk_idx) << shamt;
      take      = (ram_rdata == NODE_FREE) && (!hit_ff || (depth_ff > bestd_ff));
   end

   // next state and datapath
   always_comb begin
      state_in   = state_ff;
      node_in    = node_ff;
      best_in    = best_ff;
      depth_in   = depth_ff;
      bestd_in   = bestd_ff;
      dmax_in    = dmax_ff;
      hit_in     = hit_ff;
      clr_rsp_in = clr_rsp_ff;
      units_in   = units_ff;
      status_in  = status_ff;
      ofs_in     = ofs_ff;
      size_in    = size_ff;
      case (state_ff)
         ST_CLEAR: begin
            node_in = node_ff + AW'(1);
            if (node_ff == AW'(NODES - 1)) begin
               state_in = clr_rsp_ff ? ST_RESP : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               status_in = STATUS_OK;
               ofs_in    = '0;
               size_in   = '0;
               case (req_type)
                  REQ_ALLOC: begin
                     units_in = (units_raw == '0) ? UNITS_W'(1) : units_raw;
                     dmax_in  = DW'(TREE_LEVELS);
                     if (units_raw > UNITS_W'(LEAF_N)) begin
                        status_in = STATUS_NO_FIT;
                        state_in  = ST_RESP;
                     end else begin
                        state_in = ST_A_LVL;
                     end
                  end
                  REQ_FREE: begin
                     if (27'(leaf) >= 27'(LEAF_N)) begin
                        status_in = STATUS_BAD_FR;
                        state_in  = ST_RESP;
                     end else begin
                        node_in  = AW'(leaf) + AW'(LEAF_N - 1);
                        state_in = ST_F_RD;
                     end
                  end
                  REQ_FREE_ALL: begin
                     node_in    = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_A_LVL: begin
            // deepest level whose blocks still hold the request
            if (dmax_ff != '0 &&
                (UNITS_W'(1) << (DW'(TREE_LEVELS) - dmax_ff)) < units_ff) begin
               dmax_in = dmax_ff - DW'(1);
            end else begin
               node_in  = '0;
               depth_in = '0;
               hit_in   = 1'b0;
               state_in = ST_A_RD;
            end
         end
         ST_A_RD: begin
            state_in = ST_A_CHK;
         end
         ST_A_CHK: begin
            if (ram_rdata == NODE_SPLIT && depth_ff < dmax_ff) begin
               node_in  = {node_ff[AW-2:0], 1'b1};
               depth_in = depth_ff + DW'(1);
               state_in = ST_A_RD;
            end else if (take) begin
               hit_in   = 1'b1;
               best_in  = node_ff;
               bestd_in = depth_ff;
               state_in = (depth_ff == dmax_ff) ? ST_A_SPLIT : ST_A_UP;
            end else begin
               state_in = ST_A_UP;
            end
         end
         ST_A_UP: begin
            if (node_ff == '0) begin
               if (hit_ff) begin
                  node_in  = best_ff;
                  depth_in = bestd_ff;
                  state_in = ST_A_SPLIT;
               end else begin
                  status_in = STATUS_NO_FIT;
                  state_in  = ST_RESP;
               end
            end else if (!node_ff[0]) begin
               node_in  = parent;
               depth_in = depth_ff - DW'(1);
            end else begin
               node_in  = node_ff + AW'(1);
               state_in = ST_A_RD;
            end
         end
         ST_A_SPLIT: begin
            if (depth_ff < dmax_ff) begin
               node_in  = {node_ff[AW-2:0], 1'b1};
               depth_in = depth_ff + DW'(1);
            end else begin
               ofs_in   = ofs_wide[OFS_W-1:0];
               size_in  = size_wide[SIZE_W-1:0];
               state_in = ST_RESP;
            end
         end
         ST_F_RD: begin
            state_in = ST_F_CHK;
         end
         ST_F_CHK: begin
            if (ram_rdata == NODE_ALLOC) begin
               state_in = ST_M_RD;
            end else if (node_ff == '0 || !node_ff[0]) begin
               status_in = STATUS_BAD_FR;
               state_in  = ST_RESP;
            end else begin
               node_in  = parent;
               state_in = ST_F_RD;
            end
         end
         ST_M_RD: begin
            state_in = (node_ff == '0) ? ST_RESP : ST_M_CHK;
         end
         ST_M_CHK: begin
            if (ram_rdata == NODE_FREE) begin
               node_in  = parent;
               state_in = ST_M_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // store access and handshake outputs
   always_comb begin
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_addr  = node_ff;
      ram_wdata = NODE_FREE;
      case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
         end
         ST_A_RD, ST_F_RD: begin
            ram_re = 1'b1;
         end
         ST_M_RD: begin
            ram_re   = 1'b1;
            ram_addr = sibling;
         end
         ST_F_CHK: begin
            ram_we = (ram_rdata == NODE_ALLOC);
         end
         ST_M_CHK: begin
            ram_we   = (ram_rdata == NODE_FREE);
            ram_addr = parent;
         end
         ST_A_SPLIT: begin
            ram_we    = 1'b1;
            ram_wdata = (depth_ff < dmax_ff) ? NODE_SPLIT : NODE_ALLOC;
         end
         default: begin
            ram_we = 1'b0;
         end
      endcase
      busy             = (state_ff != ST_IDLE);
      rsp_valid        = (state_ff == ST_RESP);
      rsp_status       = status_ff;
      rsp_block_offset = ofs_ff;
      rsp_grant_size   = size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         node_ff    <= '0;
         clr_rsp_ff <= 1'b0;
         hit_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         node_ff    <= node_in;
         clr_rsp_ff <= clr_rsp_in;
         hit_ff     <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff   <= best_in;
      depth_ff  <= depth_in;
      bestd_ff  <= bestd_in;
      dmax_ff   <= dmax_in;
      units_ff  <= units_in;
      status_ff <= status_in;
      ofs_ff    <= ofs_in;
      size_ff   <= size_in;
   end

endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
// ---------------------------------------------------------------------------
// buddy_block_allocator: binary buddy allocator over a node state tree
// Allocate, free and free-all requests against a store of 2-bit node states.
// ---------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low; busy then stays
// high until the one result beat has been shown on the rsp_ ports for a single
// cycle with rsp_valid high. The result cannot be held off, so capture it on
// that cycle. After reset, and after every free-all, the block clears all the
// 2^(TREE_LEVELS+1)-1 nodes of its store one node per cycle, with busy high.
// An allocate first steps up from the leaf level one level at a time to pick
// the deepest level that still holds the request, then walks the split nodes
// depth first, one store read per node, stepping across to a right sibling or
// up to a parent, and stops early at the first free node of the target level.
// It then writes one node per cycle on the way down, one per level split plus
// the allocated node. A free walks up from the leaf of the offset to the
// allocated node, reading one node per level, then merges free buddies upward,
// reading one sibling per level. Every request ends with the result cycle. The
// node store has one port. csr_min_block_shift may be written at any time the
// block is idle; values above 16 act as 16.
module buddy_block_allocator
   import bba_pkg::*;
#(
   parameter int TREE_LEVELS = TREE_LEVELS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [SIZE_W-1:0]  req_request_size,
   input  logic [OFS_W-1:0]   req_free_offset,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [OFS_W-1:0]   rsp_block_offset,
   output logic [SIZE_W-1:0]  rsp_grant_size,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SHIFT_W-1:0] csr_min_block_shift
);

   logic [SHIFT_W-1:0]   shift_ff;
   logic [SHIFT_W-1:0]   eff_shift;
   logic                 ram_we, ram_re;
   logic [TREE_LEVELS:0] ram_addr;
   logic [1:0]           ram_wdata, ram_rdata;

   // register write is always accepted and registered
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= SHIFT_RESET;
      end else if (csr_valid && csr_ready) begin
         shift_ff <= csr_min_block_shift;
      end
   end

   // clamp the block size exponent
   assign eff_shift = (shift_ff > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : shift_ff;

   bba_ctrl #(
      .TREE_LEVELS(TREE_LEVELS)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_type         (req_type),
      .req_request_size (req_request_size),
      .req_free_offset  (req_free_offset),
      .shift            (eff_shift),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset),
      .rsp_grant_size   (rsp_grant_size),
      .ram_we           (ram_we),
      .ram_re           (ram_re),
      .ram_addr         (ram_addr),
      .ram_wdata        (ram_wdata),
      .ram_rdata        (ram_rdata)
   );

   bba_node_ram #(
      .TREE_LEVELS(TREE_LEVELS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

endmodule
